// ===== design/hrtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrtm_pkg
// Shared types, codes and helpers of the Hamming ratio-test matcher.
// ----------------------------------------------------------------------------
package hrtm_pkg;

	localparam int MAX_TARGETS_DEF = 256;
	localparam int DESC_BITS_DEF   = 256;

	localparam int WORD_W     = 64;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 3;
	localparam int REF_W      = 16;
	localparam int TIDX_W     = 8;
	localparam int DIST_W     = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	localparam int LANE_W  = 16;
	localparam int LCNT_W  = 5;
	localparam int GROUP_W = 7;

	localparam logic [DIST_W-1:0] NO_SECOND = DIST_W'(257);

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_RATIO_Q8     = CFG_IDX_W'(1);

	localparam logic [CFG_DATA_W-1:0] MAX_DISTANCE_RST = CFG_DATA_W'(257);
	localparam logic [CFG_DATA_W-1:0] RATIO_Q8_RST     = CFG_DATA_W'(205);

	typedef enum logic [OP_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_LOADED  = 3'd0,
		ST_FULL    = 3'd1,
		ST_CLEARED = 3'd2,
		ST_DONE    = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} cmd_t;

	function automatic logic [LCNT_W-1:0] popcnt16(input logic [LANE_W-1:0] v);
		logic [3:0] lo;
		logic [3:0] hi;
		lo = '0;
		hi = '0;
		for (int i = 0; i < LANE_W / 2; i++) begin
			lo = lo + 4'(v[i]);
			hi = hi + 4'(v[i + LANE_W / 2]);
		end
		return LCNT_W'(lo) + LCNT_W'(hi);
	endfunction

endpackage

// ===== design/hrtm_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrtm_ifs
// Valid/ready channels for descriptor words in and result words out.
// ----------------------------------------------------------------------------
interface hrtm_in_if;
	logic                             valid;
	logic                             ready;
	logic [hrtm_pkg::OP_W-1:0]        operation;
	logic [hrtm_pkg::WORD_W-1:0]      desc_word0;
	logic [hrtm_pkg::WORD_W-1:0]      desc_word1;
	logic [hrtm_pkg::WORD_W-1:0]      desc_word2;
	logic [hrtm_pkg::WORD_W-1:0]      desc_word3;

	modport source (output valid, operation, desc_word0, desc_word1, desc_word2,
		desc_word3, input ready);
	modport sink (input valid, operation, desc_word0, desc_word1, desc_word2,
		desc_word3, output ready);
endinterface

interface hrtm_out_if;
	logic                             valid;
	logic                             ready;
	logic [hrtm_pkg::STATUS_W-1:0]    status;
	logic                             matched;
	logic [hrtm_pkg::REF_W-1:0]       ref_index;
	logic [hrtm_pkg::TIDX_W-1:0]      target_index;
	logic [hrtm_pkg::DIST_W-1:0]      best_distance;
	logic [hrtm_pkg::DIST_W-1:0]      second_distance;

	modport source (output valid, status, matched, ref_index, target_index,
		best_distance, second_distance, input ready);
	modport sink (input valid, status, matched, ref_index, target_index,
		best_distance, second_distance, output ready);
endinterface

// ===== design/hrtm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrtm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hrtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/hrtm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrtm_front
// Accepts input words, decodes the operation, trims the descriptor and
// queues the command in a two-entry FIFO for the back end.
// ----------------------------------------------------------------------------
module hrtm_front #(
	parameter int DESC_BITS = hrtm_pkg::DESC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	hrtm_in_if.sink              in_ch,
	output hrtm_pkg::cmd_t       cmd,
	output logic [DESC_BITS-1:0] cmd_desc,
	input  logic                 cmd_ready
);

	localparam int FULL_BITS = 4 * hrtm_pkg::WORD_W;

	hrtm_pkg::op_t        ent_op_q   [2];
	logic [DESC_BITS-1:0] ent_desc_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           cnt_q;

	hrtm_pkg::op_t        in_op;
	logic [FULL_BITS-1:0] in_full;
	logic                 push;
	logic                 pop;

	assign in_op   = hrtm_pkg::op_t'(in_ch.operation);
	assign in_full = {in_ch.desc_word3, in_ch.desc_word2, in_ch.desc_word1,
		in_ch.desc_word0};

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready && (in_op != hrtm_pkg::OP_NONE);
	assign pop  = cmd.valid && cmd_ready;

	assign cmd.valid = (cnt_q != 2'd0);
	assign cmd.op    = ent_op_q[rd_ptr_q];
	assign cmd_desc  = ent_desc_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_op_q[wr_ptr_q]   <= in_op;
			ent_desc_q[wr_ptr_q] <= in_full[DESC_BITS-1:0];
		end
	end

endmodule

// ===== design/hrtm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrtm_back
// Executes queued commands: target store writes, clears, and the query scan
// through a popcount pipeline that keeps the best two distances.
// ----------------------------------------------------------------------------
module hrtm_back #(
	parameter int MAX_TARGETS = hrtm_pkg::MAX_TARGETS_DEF,
	parameter int DESC_BITS   = hrtm_pkg::DESC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hrtm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hrtm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  hrtm_pkg::cmd_t                   cmd,
	input  logic [DESC_BITS-1:0]             cmd_desc,
	output logic                             cmd_ready,
	hrtm_out_if.source                       out_ch
);

	localparam int AW      = $clog2(MAX_TARGETS);
	localparam int CW      = $clog2(MAX_TARGETS + 1);
	localparam int NL      = (DESC_BITS + hrtm_pkg::LANE_W - 1) / hrtm_pkg::LANE_W;
	localparam int NG      = (NL + 3) / 4;
	localparam int NLP     = NG * 4;
	localparam int PAD_W   = NLP * hrtm_pkg::LANE_W;
	localparam int DW      = hrtm_pkg::DIST_W;
	localparam int PROD_W  = 2 * hrtm_pkg::CFG_DATA_W;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t                             state_q;
	logic [CW-1:0]                      count_q;
	logic [hrtm_pkg::REF_W-1:0]         qcount_q;
	logic [CW-1:0]                      idx_q;
	logic [hrtm_pkg::CFG_DATA_W-1:0]    max_dist_q;
	logic [hrtm_pkg::CFG_DATA_W-1:0]    ratio_q;
	logic                               out_valid_q;

	logic                               v_s1, v_s2, v_s3, v_s4;
	logic [AW-1:0]                      idx_s1, idx_s2, idx_s3, idx_s4;
	logic [hrtm_pkg::LCNT_W-1:0]        lane_s2 [NLP];
	logic [hrtm_pkg::GROUP_W-1:0]       group_s3 [NG];
	logic [DW-1:0]                      sum_s4;

	logic [DESC_BITS-1:0]               query_q;
	logic [DW-1:0]                      best_q;
	logic [DW-1:0]                      second_q;
	logic [AW-1:0]                      best_i_q;
	logic [hrtm_pkg::REF_W-1:0]         ri_q;

	hrtm_pkg::status_t                  status_q;
	logic                               matched_q;
	logic [hrtm_pkg::REF_W-1:0]         ref_q;
	logic [hrtm_pkg::TIDX_W-1:0]        tidx_q;
	logic [DW-1:0]                      bdist_q;
	logic [DW-1:0]                      sdist_q;

	logic [DESC_BITS-1:0]               rdata;
	logic [PAD_W-1:0]                   xr_pad;
	logic [DW-1:0]                      sum_d;
	logic                               out_free;
	logic                               pop;
	logic                               is_full;
	logic                               is_empty;
	logic                               ram_we;
	logic                               ren;
	logic                               last_issue;
	logic                               pipe_busy;
	logic                               load_out;
	logic                               have_second;
	logic [PROD_W-1:0]                  rhs;
	logic [PROD_W-1:0]                  lhs;
	logic                               pass;
	logic [AW+hrtm_pkg::TIDX_W-1:0]     best_i_ext;

	assign out_free   = !out_valid_q || out_ch.ready;
	assign cmd_ready  = (state_q == S_IDLE) && out_free;
	assign pop        = cmd.valid && cmd_ready;
	assign is_full    = (count_q == CW'(MAX_TARGETS));
	assign is_empty   = (count_q == '0);
	assign ram_we     = pop && (cmd.op == hrtm_pkg::OP_LOAD) && !is_full;
	assign ren        = (state_q == S_SCAN);
	assign last_issue = (idx_q == count_q - CW'(1));
	assign pipe_busy  = v_s1 || v_s2 || v_s3 || v_s4;
	assign load_out   = (pop && (cmd.op == hrtm_pkg::OP_LOAD || cmd.op == hrtm_pkg::OP_CLEAR
		|| (cmd.op == hrtm_pkg::OP_QUERY && is_empty))) || (state_q == S_FINISH);

	assign xr_pad = PAD_W'(rdata ^ query_q);

	always_comb begin
		sum_d = '0;
		for (int g = 0; g < NG; g++) begin
			sum_d = sum_d + DW'(group_s3[g]);
		end
	end

	assign have_second = (second_q != hrtm_pkg::NO_SECOND);
	assign rhs  = PROD_W'(ratio_q) * PROD_W'(second_q);
	assign lhs  = PROD_W'({best_q, 8'd0});
	assign pass = (PROD_W'(best_q) < PROD_W'(max_dist_q))
		&& (have_second ? (lhs < rhs) : (ratio_q != '0));
	assign best_i_ext = {{hrtm_pkg::TIDX_W{1'b0}}, best_i_q};

	hrtm_ram #(
		.WIDTH (DESC_BITS),
		.DEPTH (MAX_TARGETS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (cmd_desc),
		.re    (ren),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			qcount_q    <= '0;
			idx_q       <= '0;
			max_dist_q  <= hrtm_pkg::MAX_DISTANCE_RST;
			ratio_q     <= hrtm_pkg::RATIO_Q8_RST;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == hrtm_pkg::CFG_MAX_DISTANCE) begin
					max_dist_q <= cfg_data;
				end else if (cfg_index == hrtm_pkg::CFG_RATIO_Q8) begin
					ratio_q <= cfg_data;
				end
			end

			v_s1 <= ren;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						unique case (cmd.op)
							hrtm_pkg::OP_LOAD: begin
								if (!is_full) begin
									count_q <= count_q + CW'(1);
								end
							end
							hrtm_pkg::OP_CLEAR: begin
								count_q  <= '0;
								qcount_q <= '0;
							end
							hrtm_pkg::OP_QUERY: begin
								qcount_q <= qcount_q + 16'd1;
								idx_q    <= '0;
								if (!is_empty) begin
									state_q <= S_SCAN;
								end
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (last_issue) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[AW-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		for (int l = 0; l < NLP; l++) begin
			lane_s2[l] <= hrtm_pkg::popcnt16(xr_pad[l * hrtm_pkg::LANE_W +: hrtm_pkg::LANE_W]);
		end
		for (int g = 0; g < NG; g++) begin
			group_s3[g] <= hrtm_pkg::GROUP_W'(lane_s2[4 * g])
				+ hrtm_pkg::GROUP_W'(lane_s2[4 * g + 1])
				+ hrtm_pkg::GROUP_W'(lane_s2[4 * g + 2])
				+ hrtm_pkg::GROUP_W'(lane_s2[4 * g + 3]);
		end
		sum_s4 <= sum_d;

		if (v_s4) begin
			if (sum_s4 < best_q) begin
				second_q <= best_q;
				best_q   <= sum_s4;
				best_i_q <= idx_s4;
			end else if (sum_s4 < second_q) begin
				second_q <= sum_s4;
			end
		end

		if (pop) begin
			unique case (cmd.op)
				hrtm_pkg::OP_LOAD: begin
					status_q  <= is_full ? hrtm_pkg::ST_FULL : hrtm_pkg::ST_LOADED;
					matched_q <= 1'b0;
					ref_q     <= '0;
					tidx_q    <= '0;
					bdist_q   <= '0;
					sdist_q   <= '0;
				end
				hrtm_pkg::OP_CLEAR: begin
					status_q  <= hrtm_pkg::ST_CLEARED;
					matched_q <= 1'b0;
					ref_q     <= '0;
					tidx_q    <= '0;
					bdist_q   <= '0;
					sdist_q   <= '0;
				end
				hrtm_pkg::OP_QUERY: begin
					ri_q     <= qcount_q;
					query_q  <= cmd_desc;
					best_q   <= hrtm_pkg::NO_SECOND;
					second_q <= hrtm_pkg::NO_SECOND;
					best_i_q <= '0;
					if (is_empty) begin
						status_q  <= hrtm_pkg::ST_EMPTY;
						matched_q <= 1'b0;
						ref_q     <= qcount_q;
						tidx_q    <= '0;
						bdist_q   <= '0;
						sdist_q   <= hrtm_pkg::NO_SECOND;
					end
				end
				default: ;
			endcase
		end

		if (state_q == S_FINISH) begin
			status_q  <= hrtm_pkg::ST_DONE;
			matched_q <= pass;
			ref_q     <= ri_q;
			tidx_q    <= best_i_ext[hrtm_pkg::TIDX_W-1:0];
			bdist_q   <= best_q;
			sdist_q   <= second_q;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.status          = status_q;
	assign out_ch.matched         = matched_q;
	assign out_ch.ref_index       = ref_q;
	assign out_ch.target_index    = tidx_q;
	assign out_ch.best_distance   = bdist_q;
	assign out_ch.second_distance = sdist_q;

endmodule

// ===== design/hamming_ratio_test_matcher_top.sv =====
`timescale 1ns / 1ps
// Load, clear and empty-store query words pass the front FIFO and then the back
// end's output register. A query scans the N stored targets, reading one
// target per cycle from the store RAM, then a 4-stage popcount pipeline drains.
// Throughput: one load or clear word per cycle, stalled by out_ch or a query scan.
// Reset: target count and query number go to zero, max_distance to 257 and
// ratio_q8 to 205; store contents are undefined and never read before written.
// ----------------------------------------------------------------------------
// hamming_ratio_test_matcher_top
// Brute-force Hamming descriptor matcher with a best-to-second ratio test.
// ----------------------------------------------------------------------------
module hamming_ratio_test_matcher_top #(
	parameter int MAX_TARGETS = hrtm_pkg::MAX_TARGETS_DEF,
	parameter int DESC_BITS   = hrtm_pkg::DESC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [hrtm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hrtm_pkg::CFG_DATA_W-1:0]  cfg_data,
	hrtm_in_if.sink                          in_ch,
	hrtm_out_if.source                       out_ch
);

	hrtm_pkg::cmd_t       cmd;
	logic [DESC_BITS-1:0] cmd_desc;
	logic                 cmd_ready;

	hrtm_front #(
		.DESC_BITS (DESC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cmd       (cmd),
		.cmd_desc  (cmd_desc),
		.cmd_ready (cmd_ready)
	);

	hrtm_back #(
		.MAX_TARGETS (MAX_TARGETS),
		.DESC_BITS   (DESC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.cmd_desc  (cmd_desc),
		.cmd_ready (cmd_ready),
		.out_ch    (out_ch)
	);

endmodule
